### sv/gaussian_elimination_solver_macros.svh
// ----------------------------------------------------------------------------
// gaussian_elimination_solver_macros.svh
// Assertion macros for the linear system solver.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_ELIMINATION_SOLVER_MACROS_SVH
`define GAUSSIAN_ELIMINATION_SOLVER_MACROS_SVH
`ifndef SYNTH
`define GES_ASSERT(lbl, prp, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) prp) else $error(msg);
`define GES_NEVER(lbl, cond, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define GES_ASSERT(lbl, prp, msg)
`define GES_NEVER(lbl, cond, msg)
`endif
`endif

### sv/ges_pkg.sv
// ----------------------------------------------------------------------------
// ges_pkg
// Shared types, constants and saturation helper of the solver.
// ----------------------------------------------------------------------------
package ges_pkg;

	localparam int MAX_EQ_DEF = 16;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic mat_we;
		logic wsel_coef;
		logic ld_a;
		logic ld_piv;
		logic ld_c;
		logic ld_x_mat;
		logic ld_x_sub;
		logic mul_back;
		logic sub_x;
		logic div_start;
		logic div_src_x;
		logic sol_we;
		logic ld_out;
		logic clr_fault;
	} cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(Q_MAX)) begin
			r = Q_MAX;
		end else if (v < 64'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### sv/ges_ram.sv
// ----------------------------------------------------------------------------
// ges_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ges_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/ges_div.sv
// ----------------------------------------------------------------------------
// ges_div
// Radix-2 restoring Q16.16 divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module ges_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] dividend,
	input  logic signed [31:0] divisor,
	output logic               done,
	output logic               zero,
	output logic signed [31:0] quotient
);

	logic        busy_q;
	logic        fin_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] dmag_q;
	logic        neg_q;
	logic        zero_q;
	logic signed [31:0] res_q;
	logic [32:0] sh;
	logic [32:0] dext;
	logic [31:0] amag;
	logic [31:0] bmag;

	assign sh   = {rem_q, quo_q[47]};
	assign dext = {1'b0, dmag_q};
	assign amag = dividend[31] ? 32'(-dividend) : 32'(dividend);
	assign bmag = divisor[31] ? 32'(-divisor) : 32'(divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				if (divisor == 32'sd0) begin
					zero_q <= 1'b1;
					done_q <= 1'b1;
					if (dividend > 32'sd0) begin
						res_q <= ges_pkg::Q_MAX;
					end else if (dividend < 32'sd0) begin
						res_q <= ges_pkg::Q_MIN;
					end else begin
						res_q <= 32'sd0;
					end
				end else begin
					zero_q <= 1'b0;
					busy_q <= 1'b1;
					cnt_q  <= 6'd47;
					rem_q  <= 32'd0;
					quo_q  <= {amag, 16'd0};
					dmag_q <= bmag;
					neg_q  <= dividend[31] ^ divisor[31];
				end
			end else if (busy_q) begin
				if (sh >= dext) begin
					rem_q <= 32'(sh - dext);
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= sh[31:0];
					quo_q <= {quo_q[46:0], 1'b0};
				end
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end else if (fin_q) begin
				done_q <= 1'b1;
				if (!neg_q) begin
					res_q <= (quo_q > 48'h0000_7FFF_FFFF) ? ges_pkg::Q_MAX
						: $signed(quo_q[31:0]);
				end else begin
					res_q <= (quo_q > 48'h0000_8000_0000) ? ges_pkg::Q_MIN
						: $signed(32'(-quo_q[31:0]));
				end
			end
		end
	end

	assign done     = done_q;
	assign zero     = zero_q;
	assign quotient = res_q;

endmodule

### sv/ges_dp.sv
// ----------------------------------------------------------------------------
// ges_dp
// Solver datapath: matrix and solution memories, multiply-subtract, divider.
// ----------------------------------------------------------------------------
module ges_dp #(
	parameter int MAX_EQUATIONS = ges_pkg::MAX_EQ_DEF,
	localparam int RW = $clog2(MAX_EQUATIONS),
	localparam int CW = $clog2(MAX_EQUATIONS + 1),
	localparam int AW = RW + CW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ges_pkg::cmd_t      cmd,
	input  logic signed [31:0] coefficient,
	input  logic [AW-1:0]      mat_waddr,
	input  logic [AW-1:0]      mat_raddr,
	input  logic [RW-1:0]      sol_waddr,
	input  logic [RW-1:0]      sol_raddr,
	output logic               div_done,
	output logic signed [31:0] solution_value,
	output logic               zero_pivot
);

	logic signed [31:0] mat_rd;
	logic signed [31:0] sol_rd;
	logic signed [31:0] mat_wd;
	logic signed [31:0] a_q;
	logic signed [31:0] x_q;
	logic signed [31:0] piv_q;
	logic signed [31:0] c_q;
	logic signed [31:0] out_q;
	logic signed [31:0] mul_x;
	logic signed [63:0] prod_s1;
	logic signed [63:0] rnd;
	logic signed [31:0] m_s2;
	logic signed [31:0] minuend;
	logic signed [63:0] diff;
	logic signed [31:0] sub_res;
	logic signed [31:0] quot;
	logic signed [31:0] div_a;
	logic               div_zero;
	logic               fault_q;

	ges_ram #(.WIDTH(32), .DEPTH(MAX_EQUATIONS << CW)) u_mat (
		.clk(clk), .we(cmd.mat_we), .waddr(mat_waddr), .wdata(mat_wd),
		.raddr(mat_raddr), .rdata(mat_rd)
	);

	ges_ram #(.WIDTH(32), .DEPTH(MAX_EQUATIONS)) u_sol (
		.clk(clk), .we(cmd.sol_we), .waddr(sol_waddr), .wdata(quot),
		.raddr(sol_raddr), .rdata(sol_rd)
	);

	assign div_a = cmd.div_src_x ? x_q : a_q;

	ges_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(div_a),
		.divisor(piv_q), .done(div_done), .zero(div_zero), .quotient(quot)
	);

	assign mul_x   = cmd.mul_back ? sol_rd : c_q;
	assign rnd     = prod_s1 + 64'sd32768;
	assign minuend = cmd.sub_x ? x_q : a_q;
	assign diff    = 64'(minuend) - 64'(m_s2);
	assign sub_res = ges_pkg::sat32(diff);
	assign mat_wd  = cmd.wsel_coef ? coefficient : sub_res;

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mul_x) * 64'(mat_rd);
		m_s2    <= ges_pkg::sat32(rnd >>> 16);
		if (cmd.ld_a) begin
			a_q <= mat_rd;
		end
		if (cmd.ld_piv) begin
			piv_q <= mat_rd;
		end
		if (cmd.ld_c) begin
			c_q <= quot;
		end
		if (cmd.ld_x_mat) begin
			x_q <= mat_rd;
		end else if (cmd.ld_x_sub) begin
			x_q <= sub_res;
		end
		if (cmd.ld_out) begin
			out_q <= sol_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= 1'b0;
		end else if (cmd.clr_fault) begin
			fault_q <= 1'b0;
		end else if (div_done && div_zero) begin
			fault_q <= 1'b1;
		end
	end

	assign solution_value = out_q;
	assign zero_pivot     = fault_q;

endmodule

### sv/ges_ctrl.sv
// ----------------------------------------------------------------------------
// ges_ctrl
// Solver sequencer: load, forward elimination, back substitution, output.
// ----------------------------------------------------------------------------
module ges_ctrl #(
	parameter int MAX_EQUATIONS = ges_pkg::MAX_EQ_DEF,
	localparam int RW = $clog2(MAX_EQUATIONS),
	localparam int CW = $clog2(MAX_EQUATIONS + 1),
	localparam int AW = RW + CW,
	localparam int CLW = (CW > 5) ? CW : 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [4:0]    equation_count,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          out_stall,
	output logic          out_valid,
	output logic [3:0]    variable_index,
	output logic          last_result,
	input  logic          div_done,
	output ges_pkg::cmd_t cmd,
	output logic [AW-1:0] mat_waddr,
	output logic [AW-1:0] mat_raddr,
	output logic [RW-1:0] sol_waddr,
	output logic [RW-1:0] sol_raddr
);

	typedef enum logic [4:0] {
		LOAD, E_PIV_RD, E_PIV_LD, E_A_RD, E_A_LD, E_DIV_GO, E_DIV_WAIT, E_DIV_LD,
		E_K_RDI, E_K_RDJ, E_K_MUL, E_K_WR, B_X_RD, B_X_LD, B_J_RD, B_J_P, B_J_M,
		B_J_SUB, B_P_RD, B_P_LD, B_DIV_GO, B_DIV_WAIT, B_DIV_WR, O_RD, O_LD, O_WAIT
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  n_q;
	logic [RW-1:0]  lr_q;
	logic [CW-1:0]  lc_q;
	logic [RW-1:0]  i_q;
	logic [RW-1:0]  j_q;
	logic [CW-1:0]  k_q;
	logic           valid_q;
	logic           last_q;
	logic [3:0]     idx_q;
	logic           in_acc;
	logic           load_last;
	logic [CLW-1:0] v_ext;
	logic [CLW-1:0] v_clamp;
	logic [CW-1:0]  i_w;
	logic [CW-1:0]  j_w;
	logic [CW-1:0]  lr_w;

	assign in_acc    = in_valid && !in_stall;
	assign i_w       = CW'(i_q);
	assign j_w       = CW'(j_q);
	assign lr_w      = CW'(lr_q);
	assign load_last = (lc_q == n_q) && (lr_w + CW'(1) == n_q);
	assign v_ext     = CLW'(equation_count);

	always_comb begin
		if (v_ext == '0) begin
			v_clamp = CLW'(1);
		end else if (v_ext > CLW'(MAX_EQUATIONS)) begin
			v_clamp = CLW'(MAX_EQUATIONS);
		end else begin
			v_clamp = v_ext;
		end
	end

	always_comb begin
		cmd           = '0;
		mat_raddr     = '0;
		cmd.wsel_coef = (state_q == LOAD);
		cmd.mat_we    = in_acc || (state_q == E_K_WR);
		cmd.clr_fault = in_acc && load_last;
		unique case (state_q)
			E_PIV_RD: mat_raddr = {i_q, i_w};
			E_PIV_LD: cmd.ld_piv = 1'b1;
			E_A_RD:   mat_raddr = {j_q, i_w};
			E_A_LD:   cmd.ld_a = 1'b1;
			E_DIV_GO: cmd.div_start = 1'b1;
			E_DIV_LD: cmd.ld_c = 1'b1;
			E_K_RDI:  mat_raddr = {i_q, k_q};
			E_K_RDJ:  mat_raddr = {j_q, k_q};
			E_K_MUL:  cmd.ld_a = 1'b1;
			B_X_RD:   mat_raddr = {i_q, n_q};
			B_X_LD:   cmd.ld_x_mat = 1'b1;
			B_J_RD:   mat_raddr = {i_q, j_w};
			B_J_P:    cmd.mul_back = 1'b1;
			B_J_SUB: begin
				cmd.ld_x_sub = 1'b1;
				cmd.sub_x    = 1'b1;
			end
			B_P_RD:   mat_raddr = {i_q, i_w};
			B_P_LD:   cmd.ld_piv = 1'b1;
			B_DIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_src_x = 1'b1;
			end
			B_DIV_WR: cmd.sol_we = 1'b1;
			O_LD:     cmd.ld_out = 1'b1;
			default: begin
			end
		endcase
	end

	assign mat_waddr = (state_q == LOAD) ? {lr_q, lc_q} : {j_q, k_q};
	assign sol_waddr = i_q;
	assign sol_raddr = j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			n_q     <= CW'(1);
			lr_q    <= '0;
			lc_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				n_q  <= CW'(v_clamp);
				lr_q <= '0;
				lc_q <= '0;
			end
			unique case (state_q)
				LOAD: begin
					if (in_acc) begin
						if (lc_q == n_q) begin
							lc_q <= '0;
							if (load_last) begin
								lr_q    <= '0;
								i_q     <= '0;
								state_q <= (n_q == CW'(1)) ? B_X_RD : E_PIV_RD;
							end else begin
								lr_q <= lr_q + RW'(1);
							end
						end else begin
							lc_q <= lc_q + CW'(1);
						end
					end
				end
				E_PIV_RD: state_q <= E_PIV_LD;
				E_PIV_LD: begin
					j_q     <= i_q + RW'(1);
					state_q <= E_A_RD;
				end
				E_A_RD:   state_q <= E_A_LD;
				E_A_LD:   state_q <= E_DIV_GO;
				E_DIV_GO: state_q <= E_DIV_WAIT;
				E_DIV_WAIT: begin
					if (div_done) begin
						state_q <= E_DIV_LD;
					end
				end
				E_DIV_LD: begin
					k_q     <= '0;
					state_q <= E_K_RDI;
				end
				E_K_RDI: state_q <= E_K_RDJ;
				E_K_RDJ: state_q <= E_K_MUL;
				E_K_MUL: state_q <= E_K_WR;
				E_K_WR: begin
					if (k_q == n_q) begin
						if (j_w + CW'(1) < n_q) begin
							j_q     <= j_q + RW'(1);
							state_q <= E_A_RD;
						end else if (i_w + CW'(2) < n_q) begin
							i_q     <= i_q + RW'(1);
							state_q <= E_PIV_RD;
						end else begin
							i_q     <= RW'(n_q - CW'(1));
							state_q <= B_X_RD;
						end
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= E_K_RDI;
					end
				end
				B_X_RD: state_q <= B_X_LD;
				B_X_LD: begin
					j_q     <= i_q + RW'(1);
					state_q <= (i_w + CW'(1) < n_q) ? B_J_RD : B_P_RD;
				end
				B_J_RD: state_q <= B_J_P;
				B_J_P:  state_q <= B_J_M;
				B_J_M:  state_q <= B_J_SUB;
				B_J_SUB: begin
					if (j_w + CW'(1) < n_q) begin
						j_q     <= j_q + RW'(1);
						state_q <= B_J_RD;
					end else begin
						state_q <= B_P_RD;
					end
				end
				B_P_RD:   state_q <= B_P_LD;
				B_P_LD:   state_q <= B_DIV_GO;
				B_DIV_GO: state_q <= B_DIV_WAIT;
				B_DIV_WAIT: begin
					if (div_done) begin
						state_q <= B_DIV_WR;
					end
				end
				B_DIV_WR: begin
					if (i_q == '0) begin
						j_q     <= '0;
						state_q <= O_RD;
					end else begin
						i_q     <= i_q - RW'(1);
						state_q <= B_X_RD;
					end
				end
				O_RD: state_q <= O_LD;
				O_LD: begin
					valid_q <= 1'b1;
					idx_q   <= 4'(j_q);
					last_q  <= (j_w + CW'(1) == n_q);
					state_q <= O_WAIT;
				end
				O_WAIT: begin
					if (!out_stall) begin
						valid_q <= 1'b0;
						if (last_q) begin
							state_q <= LOAD;
						end else begin
							j_q     <= j_q + RW'(1);
							state_q <= O_RD;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	assign cfg_ready      = (state_q == LOAD);
	assign in_stall       = (state_q != LOAD) || cfg_valid;
	assign out_valid      = valid_q;
	assign variable_index = idx_q;
	assign last_result    = last_q;

endmodule

### sv/gaussian_elimination_solver.sv
// ----------------------------------------------------------------------------
// gaussian_elimination_solver
// Dense Q16.16 linear system solver, elimination without pivoting.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  coefficient
// out       output     out_valid/out_stall variable_index, solution_value,
//                                          last_result, zero_pivot
// cfg       input      cfg_valid/cfg_ready equation_count
//
// Loading takes n*(n+1) entries, one entry per cycle while in_stall is low.
// Each elimination update goes through the shared multiply-subtract, and each
// divide through the bit-serial divider.
// Reset leaves n at 1 with loading at the first entry; memories are not cleared.
// Input is stalled from the last entry until the last result transfers.
// Configuration is accepted only while loading and holds off input that cycle.
// ----------------------------------------------------------------------------
`include "gaussian_elimination_solver_macros.svh"

module gaussian_elimination_solver #(
	parameter int MAX_EQUATIONS = ges_pkg::MAX_EQ_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         equation_count,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] coefficient,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         variable_index,
	output logic signed [31:0] solution_value,
	output logic               last_result,
	output logic               zero_pivot
);

	localparam int RW = $clog2(MAX_EQUATIONS);
	localparam int CW = $clog2(MAX_EQUATIONS + 1);
	localparam int AW = RW + CW;

	ges_pkg::cmd_t cmd;
	logic [AW-1:0] mat_waddr;
	logic [AW-1:0] mat_raddr;
	logic [RW-1:0] sol_waddr;
	logic [RW-1:0] sol_raddr;
	logic          div_done;

	ges_ctrl #(.MAX_EQUATIONS(MAX_EQUATIONS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.equation_count(equation_count), .in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid),
		.variable_index(variable_index), .last_result(last_result),
		.div_done(div_done), .cmd(cmd), .mat_waddr(mat_waddr),
		.mat_raddr(mat_raddr), .sol_waddr(sol_waddr), .sol_raddr(sol_raddr)
	);

	ges_dp #(.MAX_EQUATIONS(MAX_EQUATIONS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .coefficient(coefficient),
		.mat_waddr(mat_waddr), .mat_raddr(mat_raddr), .sol_waddr(sol_waddr),
		.sol_raddr(sol_raddr), .div_done(div_done),
		.solution_value(solution_value), .zero_pivot(zero_pivot)
	);

	`GES_NEVER(a_no_load_while_out, out_valid && !in_stall, "input open during output")
	`GES_ASSERT(a_last_ends, out_valid && !out_stall && last_result |=> !out_valid, "last")
	`GES_ASSERT(a_gap, out_valid && !out_stall && !last_result |=> !out_valid, "gap")
	`GES_ASSERT(a_fault_hold, out_valid && $past(out_valid) |-> $stable(zero_pivot), "flag")

endmodule

### bench/tb_gaussian_elimination_solver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gaussian_elimination_solver
// Self-checking bench for the Q16.16 Gaussian elimination solver.
// ----------------------------------------------------------------------------
// Augmented matrices are streamed in row-major order, and a local model of
// elimination and back substitution predicts every result, which is then
// compared field by field with the transfers on the output channel. Directed
// tests cover the zero pivot, saturation, count clamping and a count written
// mid-load. Random matrices follow, mostly well-conditioned with some noise,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_gaussian_elimination_solver;

	localparam int MAX_N = 16;
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		logic [3:0]         idx;
		logic signed [31:0] val;
		logic               last;
		logic               fault;
	} solution_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [4:0] equation_count;
	logic in_valid, in_stall;
	logic signed [31:0] coefficient;
	logic out_valid, out_stall;
	logic [3:0] variable_index;
	logic signed [31:0] solution_value;
	logic last_result, zero_pivot;

	solution_t expected_solutions[$];
	logic signed [31:0] aug[MAX_N][MAX_N + 1];
	logic signed [31:0] xsol[MAX_N];
	int eq_n = 1;
	int load_pos = 0;
	bit div_fault;
	bit failed = 0;
	bit calm = 0;
	int hold_off = 0;
	int idle_cycles = 0;

	gaussian_elimination_solver dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .equation_count(equation_count),
		.in_valid(in_valid), .in_stall(in_stall), .coefficient(coefficient),
		.out_valid(out_valid), .out_stall(out_stall),
		.variable_index(variable_index), .solution_value(solution_value),
		.last_result(last_result), .zero_pivot(zero_pivot)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [31:0] clip(input longint v);
		if (v > longint'(ges_pkg::Q_MAX)) return ges_pkg::Q_MAX;
		if (v < longint'(ges_pkg::Q_MIN)) return ges_pkg::Q_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b) + 32768;
		return clip(p >>> 16);
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clip(longint'(a) - longint'(b));
	endfunction

	function automatic logic signed [31:0] qdiv(input logic signed [31:0] a,
			input logic signed [31:0] b);
		if (b == 0) begin
			div_fault = 1;
			if (a > 0) return ges_pkg::Q_MAX;
			if (a < 0) return ges_pkg::Q_MIN;
			return 0;
		end
		return clip((longint'(a) * 65536) / longint'(b));
	endfunction

	function automatic void solve_system();
		logic signed [31:0] c, x;
		solution_t s;
		div_fault = 0;
		for (int i = 0; i + 1 < eq_n; i++) begin
			for (int j = i + 1; j < eq_n; j++) begin
				c = qdiv(aug[j][i], aug[i][i]);
				for (int k = 0; k <= eq_n; k++) begin
					aug[j][k] = qsub(aug[j][k], qmul(c, aug[i][k]));
				end
			end
		end
		for (int i = eq_n - 1; i >= 0; i--) begin
			x = aug[i][eq_n];
			for (int j = i + 1; j < eq_n; j++) begin
				x = qsub(x, qmul(aug[i][j], xsol[j]));
			end
			xsol[i] = qdiv(x, aug[i][i]);
		end
		for (int i = 0; i < eq_n; i++) begin
			s.idx = i[3:0];
			s.val = xsol[i];
			s.last = (i + 1 == eq_n);
			s.fault = div_fault;
			expected_solutions.push_back(s);
		end
	endfunction

	function automatic void load_entry(input logic signed [31:0] v);
		int cols;
		cols = eq_n + 1;
		if (load_pos >= eq_n * cols) load_pos = 0;
		aug[load_pos / cols][load_pos % cols] = v;
		load_pos++;
		if (load_pos == eq_n * cols) begin
			load_pos = 0;
			solve_system();
		end
	endfunction

	function automatic int pick_gap();
		if (calm || $urandom_range(99) >= 30) return 0;
		return $urandom_range(1, 4);
	endfunction

	task automatic send_coef(input logic signed [31:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coefficient <= v;
		do @(posedge clk); while (in_stall);
		load_entry(v);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_count(input logic [4:0] v);
		wait (expected_solutions.size() == 0);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		equation_count <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		eq_n = (v < 1) ? 1 : (v > MAX_N) ? MAX_N : v;
		load_pos = 0;
	endtask

	function automatic logic signed [31:0] q_int(input int v);
		return v <<< 16;
	endfunction

	task automatic send_matrix(input int kind);
		logic signed [31:0] v;
		for (int r = 0; r < eq_n; r++) begin
			for (int c = 0; c <= eq_n; c++) begin
				if (kind == 0) begin
					v = $urandom;
				end else if (r == c) begin
					v = $urandom_range(4 << 16, 9 << 16);
					if ($urandom_range(1)) v = -v;
				end else begin
					v = $urandom_range(0, 3 << 16);
					if ($urandom_range(1)) v = -v;
					if (kind == 2 && $urandom_range(9) == 0) v = $urandom;
				end
				send_coef(v);
			end
		end
		drop_valid();
	endtask

	task automatic test_single_unknown();
		send_coef(q_int(2));
		send_coef(q_int(6));
		send_coef(0);
		send_coef(q_int(5));
		send_coef(0);
		send_coef(-q_int(5));
		send_coef(0);
		send_coef(0);
		send_coef(32'sh0000_0001);
		send_coef(ges_pkg::Q_MAX);
		drop_valid();
	endtask

	task automatic test_count_limits();
		write_count(5'd0);
		send_coef(ges_pkg::Q_MIN);
		send_coef(ges_pkg::Q_MIN);
		send_coef(-1);
		send_coef(ges_pkg::Q_MAX);
		drop_valid();
		write_count(5'd2);
		send_coef(0);
		send_coef(q_int(1));
		send_coef(q_int(1));
		send_coef(q_int(1));
		send_coef(q_int(1));
		send_coef(q_int(2));
		send_coef(ges_pkg::Q_MAX);
		send_coef(ges_pkg::Q_MIN);
		send_coef(ges_pkg::Q_MAX);
		send_coef(ges_pkg::Q_MIN);
		send_coef(ges_pkg::Q_MAX);
		send_coef(32'sh5555_AAAA);
		drop_valid();
	endtask

	task automatic test_mid_load_restart();
		write_count(5'd3);
		repeat (5) send_coef($urandom);
		drop_valid();
		write_count(5'd3);
		send_matrix(1);
	endtask

	task automatic test_largest();
		write_count(5'd31);
		repeat (10) send_coef($urandom);
		drop_valid();
		write_count(5'd6);
		send_matrix(2);
	endtask

	task automatic test_backpressure();
		write_count(5'd2);
		hold_off = 3000;
		repeat (3) send_matrix(1);
	endtask

	task automatic test_random();
		int items;
		int kind;
		items = 0;
		calm = 1;
		while (items < 50) begin
			if (items > 20) calm = 0;
			write_count(5'($urandom_range(1, 4)));
			repeat ($urandom_range(1, 2)) begin
				kind = $urandom_range(9);
				send_matrix(kind < 2 ? 0 : kind < 4 ? 2 : 1);
				items += eq_n * (eq_n + 1);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		solution_t s;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_solutions.size() == 0) begin
					$display("%0t: unexpected result index %0d value %h", $time,
						variable_index, solution_value);
					failed = 1;
				end else begin
					s = expected_solutions.pop_front();
					if (variable_index !== s.idx || solution_value !== s.val ||
							last_result !== s.last || zero_pivot !== s.fault) begin
						$display("%0t: expected idx %0d val %h last %b fault %b,",
							$time, s.idx, s.val, s.last, s.fault);
						$display("%0t: got idx %0d val %h last %b fault %b",
							$time, variable_index, solution_value, last_result,
							zero_pivot);
						failed = 1;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 30);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		equation_count = 5'd1;
		in_valid = 1'b0;
		coefficient = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_unknown();
		test_count_limits();
		test_mid_load_restart();
		test_largest();
		test_backpressure();
		test_random();
		wait (expected_solutions.size() == 0);
		repeat (50) @(posedge clk);
		if (!failed) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/ges_pkg.sv
sv/ges_ram.sv
sv/ges_div.sv
sv/ges_dp.sv
sv/ges_ctrl.sv
sv/gaussian_elimination_solver.sv
bench/tb_gaussian_elimination_solver.sv
